// ===== rtl/core/i2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and helpers of the integer to ascii formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // operand and character widths
    localparam int VALUE_BITS = 32;
    localparam int OP_W       = 3;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = 4;
    localparam int PROD_W     = 2 * VALUE_BITS;

    // divide by ten through a reciprocal: q = (v * RECIP10) >> RECIP_SHIFT
    localparam logic [VALUE_BITS-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                    RECIP_SHIFT = 35;
    localparam int                    QUOT_W      = PROD_W - RECIP_SHIFT;

    // ascii constants
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // opcodes
    localparam logic [OP_W-1:0] OP_CHAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_HEX   = 3'd1;
    localparam logic [OP_W-1:0] OP_UDEC  = 3'd2;
    localparam logic [OP_W-1:0] OP_SDEC  = 3'd3;
    localparam logic [OP_W-1:0] OP_GROUP = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic q_zero;
        logic out_free;
        logic cur_last;
    } status_t;

    // one nibble to an uppercase hex digit, decimal digits map the same way
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [DIGIT_W-1:0] nib);
        logic [CHAR_W-1:0] res;
        if (nib < 4'd10)
        begin
            res = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            res = CH_UPA + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Char and hex requests go from the load straight to emission; decimal requests first take
//   one multiply and one divide step per digit. A new request is taken only after the last
//   character of the previous one is emitted, paced by the shared reciprocal divider and the
//   single output register.
// Reset: rst_n clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one 32-bit operand as a stream of ascii characters, last one flagged; reserved opcodes emit nothing.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] value
    input  wire  [7:0]  s_tuser,   // [2:0] op, [7:3] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic        m_tlast    // last
);

    i2a_pkg::cmd_t    cmd;
    i2a_pkg::status_t status;

    // sequencer
    i2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[2:0]),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    i2a_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_tuser[2:0]),
        .in_value  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
`default_nettype wire

// ===== rtl/core/i2a_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: accepts a request, steps digit extraction, paces emission.
// ----------------------------------------------------------------------------
module i2a_ctrl (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire  [i2a_pkg::OP_W-1:0]         in_op,
    output logic                             in_ready,
    input  i2a_pkg::status_t                 status,
    output i2a_pkg::cmd_t                    cmd
);

    i2a_pkg::state_t state_reg;
    i2a_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2a_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (in_op)
                        i2a_pkg::OP_CHAR,
                        i2a_pkg::OP_HEX:   state_next = i2a_pkg::ST_EMIT;
                        i2a_pkg::OP_UDEC,
                        i2a_pkg::OP_SDEC,
                        i2a_pkg::OP_GROUP: state_next = i2a_pkg::ST_MUL;
                        default:           state_next = i2a_pkg::ST_IDLE;
                    endcase
                end
            end
            i2a_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = i2a_pkg::ST_DIV;
            end
            i2a_pkg::ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = status.q_zero ? i2a_pkg::ST_EMIT : i2a_pkg::ST_MUL;
            end
            i2a_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.cur_last)
                    begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/i2a_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_datapath
// Operand, reciprocal divider, digit store, character select, output register.
// ----------------------------------------------------------------------------
module i2a_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  [i2a_pkg::OP_W-1:0]             in_op,
    input  wire  [i2a_pkg::VALUE_BITS-1:0]       in_value,
    input  i2a_pkg::cmd_t                        cmd,
    output i2a_pkg::status_t                     status,
    output logic [i2a_pkg::CHAR_W-1:0]           out_char,
    output logic                                 out_last,
    output logic                                 out_valid,
    input  wire                                  out_ready
);

    logic [i2a_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [i2a_pkg::PROD_W-1:0]     prod_reg;
    logic [i2a_pkg::DIGIT_W-1:0]    digits_reg [i2a_pkg::MAX_DIGITS];
    logic [i2a_pkg::DIGIT_W-1:0]    digits_next [i2a_pkg::MAX_DIGITS];
    logic [i2a_pkg::CNT_W-1:0]      ndig_reg, ndig_next;
    logic [i2a_pkg::CNT_W-1:0]      pos_reg, pos_next;
    logic                           pre_reg, pre_next;
    logic [i2a_pkg::CHAR_W-1:0]     pre_char_reg, pre_char_next;
    logic                           space_reg, space_next;
    logic                           grouped_reg, grouped_next;
    logic [i2a_pkg::CHAR_W-1:0]     out_char_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg, out_valid_next;

    logic [i2a_pkg::QUOT_W-1:0]     quot;
    logic [i2a_pkg::VALUE_BITS-1:0] quot_ext;
    logic [i2a_pkg::VALUE_BITS-1:0] rem_full;
    logic                           neg;
    logic [i2a_pkg::CHAR_W-1:0]     cur_char;
    logic                           cur_last;
    logic                           group_mark;

    // quotient and remainder of the held product
    assign quot     = prod_reg[i2a_pkg::PROD_W-1:i2a_pkg::RECIP_SHIFT];
    assign quot_ext = {{(i2a_pkg::VALUE_BITS - i2a_pkg::QUOT_W){1'b0}}, quot};
    assign rem_full = value_reg - (quot_ext << 3) - (quot_ext << 1);
    assign neg      = in_value[i2a_pkg::VALUE_BITS-1];

    // a space follows digits at positions three, six and nine
    assign group_mark = grouped_reg &&
                        (pos_reg == 4'd3 || pos_reg == 4'd6 || pos_reg == 4'd9);

    // character now due
    always_comb
    begin
        priority if (pre_reg)
        begin
            cur_char = pre_char_reg;
            cur_last = (ndig_reg == '0);
        end
        else if (space_reg)
        begin
            cur_char = i2a_pkg::CH_SPACE;
            cur_last = 1'b0;
        end
        else
        begin
            cur_char = i2a_pkg::hex_digit(digits_reg[pos_reg]);
            cur_last = (pos_reg == '0);
        end
    end

    // next values of the working registers
    always_comb
    begin
        value_next    = value_reg;
        digits_next   = digits_reg;
        ndig_next     = ndig_reg;
        pos_next      = pos_reg;
        pre_next      = pre_reg;
        pre_char_next = pre_char_reg;
        space_next    = space_reg;
        grouped_next  = grouped_reg;
        if (cmd.load)
        begin
            value_next    = (in_op == i2a_pkg::OP_SDEC && neg) ? (~in_value + 32'd1)
                                                               : in_value;
            pre_next      = (in_op == i2a_pkg::OP_CHAR) ||
                            (in_op == i2a_pkg::OP_SDEC && neg);
            pre_char_next = (in_op == i2a_pkg::OP_CHAR) ? in_value[7:0]
                                                        : i2a_pkg::CH_MINUS;
            grouped_next  = (in_op == i2a_pkg::OP_GROUP);
            space_next    = 1'b0;
            digits_next[0] = in_value[3:0];
            digits_next[1] = in_value[7:4];
            if (in_op == i2a_pkg::OP_HEX)
            begin
                ndig_next = 4'd2;
                pos_next  = 4'd1;
            end
            else
            begin
                ndig_next = '0;
                pos_next  = '0;
            end
        end
        else if (cmd.div)
        begin
            // digit k from the right lands in slot k
            digits_next[ndig_reg] = rem_full[i2a_pkg::DIGIT_W-1:0];
            pos_next   = ndig_reg;
            ndig_next  = ndig_reg + 4'd1;
            value_next = quot_ext;
        end
        else if (cmd.emit)
        begin
            priority if (pre_reg)
            begin
                pre_next = 1'b0;
            end
            else if (space_reg)
            begin
                space_next = 1'b0;
                pos_next   = pos_reg - 4'd1;
            end
            else if (pos_reg != '0)
            begin
                if (group_mark)
                begin
                    space_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg - 4'd1;
                end
            end
            else
            begin
                // final digit, nothing left to step
                pos_next = pos_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        digits_reg   <= digits_next;
        ndig_reg     <= ndig_next;
        pos_reg      <= pos_next;
        pre_char_reg <= pre_char_next;
        grouped_reg  <= grouped_next;
        if (cmd.mul)
        begin
            prod_reg <= {{i2a_pkg::VALUE_BITS{1'b0}}, value_reg} *
                        {{i2a_pkg::VALUE_BITS{1'b0}}, i2a_pkg::RECIP10};
        end
        if (cmd.emit)
        begin
            out_char_reg <= cur_char;
            out_last_reg <= cur_last;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg       <= 1'b0;
            space_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pre_reg       <= pre_next;
            space_reg     <= space_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register handshake
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign status.q_zero   = (quot == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.cur_last = cur_last;

    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to ascii formatter. Requests carry an
// opcode and a 32-bit operand. A scoreboard formats each accepted request on
// its own and compares the character stream, char by char and tlast by tlast,
// against what the unit emits. Directed corner cases come first, then random
// traffic under three idling profiles on the request and result sides.
// ----------------------------------------------------------------------------
module tb_top;

    import i2a_pkg::*;

    // opcodes the unit must swallow without emitting anything
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } glyph_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [7:0]  s_tuser;   // [2:0] op, [7:3] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] char_out
    logic        m_tlast;   // last

    glyph_t expected_glyphs[$];
    int     mismatches;
    int     requests_taken;
    int     quiet_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    integer_to_ascii_formatter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always #5 clk = ~clk;

    // nibble to uppercase hex character
    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + {4'd0, nib};
        end
        return CH_UPA + {4'd0, nib} - 8'd10;
    endfunction

    // format one request and queue the characters it should produce
    function automatic void format_value(input logic [OP_W-1:0] op, input logic [31:0] operand);
        logic [CHAR_W-1:0] text[$];
        logic [3:0]        digits[MAX_DIGITS];
        logic [31:0]       mag;
        int                n;
        glyph_t            g;
        n   = 0;
        mag = operand;
        case (op)
            OP_CHAR:
            begin
                text.push_back(operand[7:0]);
            end
            OP_HEX:
            begin
                text.push_back(nibble_char(operand[7:4]));
                text.push_back(nibble_char(operand[3:0]));
            end
            OP_UDEC, OP_SDEC, OP_GROUP:
            begin
                // two's complement magnitude, most negative value stays unsigned
                if (op == OP_SDEC && operand[31])
                begin
                    text.push_back(CH_MINUS);
                    mag = ~operand + 32'd1;
                end
                do
                begin
                    digits[n] = 4'(mag % 32'd10);
                    mag       = mag / 32'd10;
                    n++;
                end
                while (mag != 0);
                for (int pos = n - 1; pos >= 0; pos--)
                begin
                    text.push_back(CH_ZERO + {4'd0, digits[pos]});
                    if (op == OP_GROUP && pos != 0 && (pos % 3) == 0)
                    begin
                        text.push_back(CH_SPACE);
                    end
                end
            end
            default:
            begin
            end
        endcase
        foreach (text[i])
        begin
            g.ch   = text[i];
            g.last = (i == text.size() - 1);
            expected_glyphs.push_back(g);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch %s: got %02h expected %02h", $realtime, what, got, want);
        mismatches++;
    endtask

    // scoreboard: predict on request, check on result, watch for hangs
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                format_value(s_tuser[OP_W-1:0], s_tdata);
                requests_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    report_mismatch("unexpected character", m_tdata, 8'h00);
                end
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        report_mismatch("char_out", m_tdata, want.ch);
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch("last", {7'd0, m_tlast}, {7'd0, want.last});
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // drive one request and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] operand);
        int taken_so_far;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        taken_so_far = requests_taken;
        s_tvalid     <= 1'b1;
        s_tdata      <= operand;
        s_tuser      <= {5'd0, op};
        do
        begin
            @(negedge clk);
        end
        while (requests_taken == taken_so_far);
    endtask

    task automatic test_raw_chars();
        send_request(OP_CHAR, 32'h0000_0000);
        send_request(OP_CHAR, 32'h0000_00FF);
        send_request(OP_CHAR, 32'hFFFF_FF41);
    endtask

    task automatic test_hex_bytes();
        // leading zero below sixteen
        send_request(OP_HEX, 32'h0000_0000);
        send_request(OP_HEX, 32'h0000_000F);
        send_request(OP_HEX, 32'h1234_56A5);
        send_request(OP_HEX, 32'hFFFF_FFFF);
    endtask

    task automatic test_unsigned_decimal();
        send_request(OP_UDEC, 32'd0);
        send_request(OP_UDEC, 32'd9);
        send_request(OP_UDEC, 32'd10);
        send_request(OP_UDEC, 32'hFFFF_FFFF);
    endtask

    task automatic test_signed_decimal();
        // most negative value prints its full magnitude
        send_request(OP_SDEC, 32'd0);
        send_request(OP_SDEC, 32'h7FFF_FFFF);
        send_request(OP_SDEC, 32'h8000_0000);
        send_request(OP_SDEC, 32'hFFFF_FFFF);
    endtask

    task automatic test_grouped_decimal();
        send_request(OP_GROUP, 32'd0);
        send_request(OP_GROUP, 32'd999);
        send_request(OP_GROUP, 32'd1000);
        send_request(OP_GROUP, 32'd1234567);
        send_request(OP_GROUP, 32'hFFFF_FFFF);
    endtask

    task automatic test_unused_ops();
        send_request(OP_RSVD5, 32'hFFFF_FFFF);
        send_request(OP_RSVD6, 32'h0000_0000);
        send_request(OP_RSVD7, 32'hA5A5_5A5A);
    endtask

    // operand mix aimed at digit-count and sign boundaries
    function automatic logic [31:0] pick_operand();
        logic [31:0] pow;
        pow = 32'd1;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 9999);
            2:
            begin
                repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
                return pow + $urandom_range(0, 2) - 32'd1;
            end
            3: return -$urandom_range(1, 100000);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // random traffic, ignored opcodes not counted
    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        int          sent;
        logic [OP_W-1:0] op;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
            end
            else
            begin
                op = OP_W'($urandom_range(OP_CHAR, OP_GROUP));
                sent++;
            end
            send_request(op, pick_operand());
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        mismatches     = 0;
        requests_taken = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 54;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_raw_chars();
        test_hex_bytes();
        test_unsigned_decimal();
        test_signed_decimal();
        test_grouped_decimal();
        test_unused_ops();
        test_random_mix(100, 12, 54);
        test_random_mix(100, 54, 12);
        test_random_mix(100, 0, 0);
        s_tvalid <= 1'b0;

        // drain, then give stray characters a chance to show up
        while (expected_glyphs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
